FILE: rtl/bpp_pkg.sv
// shared types, constants and fixed-point helpers of the boris particle push core
package bpp_pkg;

	localparam int FRAC = 16;
	localparam int CELL_QW = 10;
	localparam int SDIV_QW = 16;
	localparam logic [63:0] TAN_Q32 = 64'd1779033704;
	localparam logic [31:0] TAN_LIM = 32'(((TAN_Q32 >> (31 - FRAC)) + 64'd1) >> 1);

	localparam logic [2:0] CFG_K     = 3'd0;
	localparam logic [2:0] CFG_DT    = 3'd1;
	localparam logic [2:0] CFG_H     = 3'd2;
	localparam logic [2:0] CFG_XMAX  = 3'd3;
	localparam logic [2:0] CFG_YMAX  = 3'd4;
	localparam logic [2:0] CFG_MODES = 3'd5;
	localparam logic [2:0] CFG_HALF  = 3'd6;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_GONE = 3'd1;
	localparam logic [2:0] ST_ROT  = 3'd2;
	localparam logic [2:0] ST_CFL  = 3'd3;
	localparam logic [2:0] ST_MOVE = 3'd4;

	localparam logic [1:0] BND_PERIODIC = 2'd0;
	localparam logic [1:0] BND_OPEN     = 2'd1;

	typedef logic signed [31:0] word_t;

	typedef enum logic [1:0] {MV_OK, MV_GONE, MV_SKIP} mv_code_t;

	typedef struct packed {
		mv_code_t r;
		logic [30:0] np;
		word_t v;
	} mv_t;

	typedef struct packed {
		word_t k;
		logic [30:0] dt;
		logic [30:0] h;
		logic [30:0] xmax;
		logic [30:0] ymax;
		logic [7:0] modes;
		logic half;
	} cfg_t;

	typedef struct packed {
		word_t [2:0] v;
		word_t [2:0] e;
		word_t [2:0] b;
		logic [30:0] px;
		logic [30:0] py;
	} in_t;

	typedef struct packed {
		word_t [2:0] v;
		word_t [2:0] e;
		word_t [2:0] b;
		word_t [2:0] t;
		word_t [2:0] kick;
		logic [30:0] px;
		logic [30:0] py;
		logic rot;
	} fq_t;

	typedef struct packed {
		word_t [2:0] vel;
		logic [30:0] px;
		logic [30:0] py;
		logic [9:0] col;
		logic [9:0] row;
		logic [2:0] st;
		logic warn;
	} res_t;

	function automatic word_t sat64(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
		else if (x < -64'sd2147483648) return 32'sh80000000;
		else return x[31:0];
	endfunction

	// round to nearest, ties up, then saturate
	function automatic word_t fmul(input word_t a, input word_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd32768;
		p = p >>> FRAC;
		return sat64(p);
	endfunction

	function automatic word_t fadd(input word_t a, input word_t b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return sat64(64'(s));
	endfunction

	function automatic word_t fsub(input word_t a, input word_t b);
		logic signed [32:0] s;
		s = 33'(a) - 33'(b);
		return sat64(64'(s));
	endfunction

	function automatic logic signed [47:0] mul_raw(input logic [30:0] dt, input word_t v);
		logic signed [63:0] p;
		p = $signed({33'b0, dt}) * 64'(v);
		p = p + 64'sd32768;
		p = p >>> FRAC;
		return p[47:0];
	endfunction

	function automatic logic [31:0] abs_w(input word_t v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic word_t neg_sat(input word_t v);
		return (v == 32'sh80000000) ? 32'sh7FFFFFFF : -v;
	endfunction

	function automatic mv_t move_axis(input logic signed [49:0] x, input logic [40:0] lo,
		input logic [30:0] h, input logic [30:0] lim, input logic [1:0] ml,
		input logic [1:0] mr, input word_t v);
		mv_t m;
		logic signed [49:0] lo_s;
		logic signed [49:0] h_s;
		logic signed [49:0] lim_s;
		logic signed [49:0] y;
		lo_s = $signed({9'b0, lo});
		h_s = $signed({19'b0, h});
		lim_s = $signed({19'b0, lim});
		m.r = MV_OK;
		m.v = v;
		y = x;
		if ((x <= lo_s - h_s) || (x >= lo_s + h_s + h_s)) begin
			m.r = MV_SKIP;
		end else if (x < 0) begin
			case (ml)
				BND_PERIODIC: y = x + lim_s;
				BND_OPEN: m.r = MV_GONE;
				default: begin
					y = -x;
					m.v = neg_sat(v);
				end
			endcase
		end else if (x > lim_s) begin
			case (mr)
				BND_PERIODIC: y = x - lim_s;
				BND_OPEN: m.r = MV_GONE;
				default: begin
					y = lim_s + lim_s - x;
					m.v = neg_sat(v);
				end
			endcase
		end
		if (y < 0) y = 0;
		if (y > lim_s) y = lim_s;
		m.np = y[30:0];
		return m;
	endfunction

endpackage

FILE: rtl/bpp_front.sv
// front end: takes particles, computes t and the half kick, flags large rotations
module bpp_front
	import bpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	input  word_t k,
	input  logic q_full,
	output logic busy,
	output logic push,
	output fq_t push_item
);

	in_t f1_q;
	logic f1_vld_q;
	logic ready;
	logic accept;

	assign push = f1_vld_q && !q_full;
	assign ready = !f1_vld_q || !q_full;
	assign busy = !ready;
	assign accept = start && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_vld_q <= 1'b0;
		end else begin
			f1_vld_q <= accept || (f1_vld_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f1_q <= item;
		end
	end

	always_comb begin
		push_item.v = f1_q.v;
		push_item.e = f1_q.e;
		push_item.b = f1_q.b;
		push_item.px = f1_q.px;
		push_item.py = f1_q.py;
		push_item.rot = 1'b0;
		for (int i = 0; i < 3; i++) begin
			push_item.t[i] = fmul(k, f1_q.b[i]);
			push_item.kick[i] = fmul(k, f1_q.e[i]);
			if (abs_w(push_item.t[i]) > TAN_LIM) push_item.rot = 1'b1;
		end
	end

endmodule

FILE: rtl/bpp_queue.sv
// two-entry queue between front end and back end
module bpp_queue
	import bpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fq_t  push_item,
	output logic full,
	output logic pop,
	output fq_t  pop_item
);

	fq_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	// the back end never stalls, so every waiting entry leaves at once
	assign pop = (cnt_q != 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && !push) |=> cnt_q == 2'd0) else $error("queue entry not drained");
`endif

endmodule

FILE: rtl/bpp_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module bpp_div #(
	parameter int NW = 32,
	parameter int DW = 17,
	parameter int QW = 16
) (
	input  logic clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int W = NW + DW;

	logic [W-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic ovf_s [0:QW];

	always_ff @(posedge clk) begin
		rem_s[0] <= W'(num);
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= W'(num) >= (W'(den) << QW);
	end

	for (genvar g = 0; g < QW; g++) begin : g_step
		localparam int SH = QW - 1 - g;
		logic [W-1:0] trial;
		assign trial = W'(den_s[g]) << SH;
		always_ff @(posedge clk) begin
			if (rem_s[g] >= trial) begin
				rem_s[g+1] <= rem_s[g] - trial;
				quo_s[g+1] <= quo_s[g] | (QW'(1) << SH);
			end else begin
				rem_s[g+1] <= rem_s[g];
				quo_s[g+1] <= quo_s[g];
			end
			den_s[g+1] <= den_s[g];
			ovf_s[g+1] <= ovf_s[g];
		end
	end

	assign quo = ovf_s[QW] ? '1 : quo_s[QW];

endmodule

FILE: rtl/bpp_back.sv
// back end: boris rotation, courant check, boundary rules and cell lookup
module bpp_back
	import bpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	input  fq_t  in_item,
	output logic out_valid,
	output res_t out_item
);

	localparam int CDIV_LAT = CELL_QW + 1;
	localparam int SDIV_LAT = SDIV_QW + 1;
	localparam int CIN_TAP = 2;
	localparam int S_TAP = 3;
	localparam int CIN_OUT = CIN_TAP + CDIV_LAT;
	localparam int S_OUT = S_TAP + SDIV_LAT;
	localparam int COUT_TAP = S_OUT + 9;
	localparam int LAST = COUT_TAP + CDIV_LAT;

	typedef struct packed {
		word_t [2:0] v;
		word_t [2:0] e;
		word_t [2:0] b;
		word_t [2:0] t;
		word_t [2:0] kick;
		word_t [2:0] tt;
		word_t [2:0] tmp;
		word_t [2:0] vm;
		word_t [2:0] vd;
		word_t [2:0] s;
		word_t [2:0] vn;
		word_t [2:0] ov;
		word_t [5:0] pr;
		logic [2:0][16:0] den;
		logic [2:0][31:0] numh;
		logic [30:0] px;
		logic [30:0] py;
		logic [30:0] cpx;
		logic [30:0] cpy;
		logic [30:0] opx;
		logic [30:0] opy;
		logic [40:0] lox;
		logic [40:0] loy;
		logic [32:0] sum;
		logic signed [47:0] dx;
		logic signed [47:0] dy;
		logic signed [49:0] xx;
		logic signed [49:0] xy;
		logic [63:0] prod;
		mv_t mvx;
		mv_t mvy;
		logic rot;
		logic warn;
		logic stop;
		logic [2:0] st;
	} bk_t;

	bk_t pipe_s [1:LAST];
	bk_t nx [1:LAST];
	logic vld_s [1:LAST];

	logic [30:0] hv;
	logic [30:0] xlim;
	logic [30:0] ylim;
	logic [63:0] hf;
	logic [63:0] hf15;
	logic [SDIV_QW-1:0] sq [3];
	logic [CELL_QW-1:0] cix;
	logic [CELL_QW-1:0] ciy;
	logic [CELL_QW-1:0] cox;
	logic [CELL_QW-1:0] coy;
	res_t out_q;
	logic done_q;

	assign hv = (cfg.h == '0) ? 31'd1 : cfg.h;
	assign xlim = (cfg.xmax == '0) ? 31'd1 : cfg.xmax;
	assign ylim = (cfg.ymax == '0) ? 31'd1 : cfg.ymax;
	assign hf = 64'(hv) << FRAC;
	assign hf15 = hf + (64'(hv) << (FRAC - 1));

	for (genvar g = 0; g < 3; g++) begin : g_sdiv
		bpp_div #(.NW(32), .DW(17), .QW(SDIV_QW)) u_sdiv (
			.clk(clk),
			.num(pipe_s[S_TAP].numh[g]),
			.den(pipe_s[S_TAP].den[g]),
			.quo(sq[g])
		);
	end

	bpp_div #(.NW(31), .DW(31), .QW(CELL_QW)) u_cin_x (
		.clk(clk), .num(pipe_s[CIN_TAP].cpx), .den(hv), .quo(cix));
	bpp_div #(.NW(31), .DW(31), .QW(CELL_QW)) u_cin_y (
		.clk(clk), .num(pipe_s[CIN_TAP].cpy), .den(hv), .quo(ciy));
	bpp_div #(.NW(31), .DW(31), .QW(CELL_QW)) u_cout_x (
		.clk(clk), .num(pipe_s[COUT_TAP].cpx), .den(hv), .quo(cox));
	bpp_div #(.NW(31), .DW(31), .QW(CELL_QW)) u_cout_y (
		.clk(clk), .num(pipe_s[COUT_TAP].cpy), .den(hv), .quo(coy));

	always_comb begin
		int j;
		int l;
		logic [16:0] dn;
		logic [31:0] at;
		logic [31:0] qq;
		bk_t p;
		for (int n = 1; n < LAST; n++) nx[n+1] = pipe_s[n];

		nx[1] = '0;
		nx[1].v = in_item.v;
		nx[1].e = in_item.e;
		nx[1].b = in_item.b;
		nx[1].t = in_item.t;
		nx[1].kick = in_item.kick;
		nx[1].px = in_item.px;
		nx[1].py = in_item.py;
		nx[1].rot = in_item.rot;

		// v x B products, t squared, clamp of the input position
		p = pipe_s[1];
		for (int i = 0; i < 3; i++) begin
			j = (i == 2) ? 0 : i + 1;
			l = (i == 0) ? 2 : i - 1;
			nx[2].pr[2*i] = fmul(p.v[j], p.b[l]);
			nx[2].pr[2*i+1] = fmul(p.v[l], p.b[j]);
			nx[2].tt[i] = fmul(p.t[i], p.t[i]);
		end
		nx[2].cpx = (p.px > xlim - 31'd1) ? xlim - 31'd1 : p.px;
		nx[2].cpy = (p.py > ylim - 31'd1) ? ylim - 31'd1 : p.py;

		// E + v x B, divider operands for s = 2t/(1+t^2)
		p = pipe_s[2];
		for (int i = 0; i < 3; i++) begin
			nx[3].tmp[i] = fadd(p.e[i], fsub(p.pr[2*i], p.pr[2*i+1]));
			dn = 17'h10000 + p.tt[i][16:0];
			at = abs_w(p.t[i]);
			nx[3].den[i] = dn;
			nx[3].numh[i] = {at[14:0], 17'b0} + 32'(dn >> 1);
		end

		p = pipe_s[3];
		for (int i = 0; i < 3; i++) nx[4].tmp[i] = fmul(cfg.k, p.tmp[i]);

		// optional half step back, then first half kick
		p = pipe_s[4];
		for (int i = 0; i < 3; i++) begin
			nx[5].vm[i] = fadd(cfg.half ? fsub(p.v[i], p.tmp[i]) : p.v[i], p.kick[i]);
		end

		p = pipe_s[5];
		for (int i = 0; i < 3; i++) begin
			j = (i == 2) ? 0 : i + 1;
			l = (i == 0) ? 2 : i - 1;
			nx[6].pr[2*i] = fmul(p.vm[j], p.t[l]);
			nx[6].pr[2*i+1] = fmul(p.vm[l], p.t[j]);
		end

		p = pipe_s[6];
		for (int i = 0; i < 3; i++) begin
			nx[7].vd[i] = fadd(p.vm[i], fsub(p.pr[2*i], p.pr[2*i+1]));
		end

		// lower edge of the starting cell
		p = pipe_s[CIN_OUT];
		nx[CIN_OUT+1].lox = 41'(cix) * 41'(hv);
		nx[CIN_OUT+1].loy = 41'(ciy) * 41'(hv);

		p = pipe_s[S_OUT];
		for (int i = 0; i < 3; i++) begin
			qq = {16'b0, sq[i]};
			nx[S_OUT+1].s[i] = p.t[i][31] ? (32'd0 - qq) : qq;
		end

		p = pipe_s[S_OUT+1];
		for (int i = 0; i < 3; i++) begin
			j = (i == 2) ? 0 : i + 1;
			l = (i == 0) ? 2 : i - 1;
			nx[S_OUT+2].pr[2*i] = fmul(p.vd[j], p.s[l]);
			nx[S_OUT+2].pr[2*i+1] = fmul(p.vd[l], p.s[j]);
		end

		p = pipe_s[S_OUT+2];
		for (int i = 0; i < 3; i++) begin
			nx[S_OUT+3].vn[i] = fadd(p.vm[i], fsub(p.pr[2*i], p.pr[2*i+1]));
		end

		p = pipe_s[S_OUT+3];
		for (int i = 0; i < 3; i++) nx[S_OUT+4].vn[i] = fadd(p.vn[i], p.kick[i]);

		p = pipe_s[S_OUT+4];
		nx[S_OUT+5].sum = 33'(abs_w(p.vn[0])) + 33'(abs_w(p.vn[1])) + 33'(abs_w(p.vn[2]));
		nx[S_OUT+5].dx = mul_raw(cfg.dt, p.vn[0]);
		nx[S_OUT+5].dy = mul_raw(cfg.dt, p.vn[1]);

		p = pipe_s[S_OUT+5];
		nx[S_OUT+6].prod = 64'(p.sum) * 64'(cfg.dt);
		nx[S_OUT+6].xx = $signed({19'b0, p.px}) + 50'(p.dx);
		nx[S_OUT+6].xy = $signed({19'b0, p.py}) + 50'(p.dy);

		p = pipe_s[S_OUT+6];
		nx[S_OUT+7].warn = p.prod > hf;
		nx[S_OUT+7].stop = p.prod > hf15;
		nx[S_OUT+7].mvx = move_axis(p.xx, p.lox, hv, xlim, cfg.modes[1:0], cfg.modes[3:2],
			p.vn[0]);
		nx[S_OUT+7].mvy = move_axis(p.xy, p.loy, hv, ylim, cfg.modes[5:4], cfg.modes[7:6],
			p.vn[1]);

		// status priority: rotation, courant stop, x move, y move
		p = pipe_s[S_OUT+7];
		nx[S_OUT+8].ov = p.v;
		nx[S_OUT+8].opx = p.px;
		nx[S_OUT+8].opy = p.py;
		nx[S_OUT+8].warn = p.warn && !p.rot;
		nx[S_OUT+8].st = ST_OK;
		if (p.rot) begin
			nx[S_OUT+8].st = ST_ROT;
		end else if (p.stop) begin
			nx[S_OUT+8].st = ST_CFL;
		end else if (p.mvx.r == MV_SKIP) begin
			nx[S_OUT+8].st = ST_MOVE;
		end else if (p.mvx.r == MV_GONE || (p.mvy.r == MV_GONE)) begin
			if (p.mvx.r != MV_GONE && p.mvy.r == MV_SKIP) begin
				nx[S_OUT+8].st = ST_MOVE;
			end else begin
				nx[S_OUT+8].st = ST_GONE;
				nx[S_OUT+8].ov = '0;
				nx[S_OUT+8].opx = '0;
				nx[S_OUT+8].opy = '0;
			end
		end else if (p.mvy.r == MV_SKIP) begin
			nx[S_OUT+8].st = ST_MOVE;
		end else begin
			nx[S_OUT+8].ov = {p.vn[2], p.mvy.v, p.mvx.v};
			nx[S_OUT+8].opx = p.mvx.np;
			nx[S_OUT+8].opy = p.mvy.np;
		end

		p = pipe_s[S_OUT+8];
		nx[COUT_TAP].cpx = (p.opx > xlim - 31'd1) ? xlim - 31'd1 : p.opx;
		nx[COUT_TAP].cpy = (p.opy > ylim - 31'd1) ? ylim - 31'd1 : p.opy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= LAST; n++) vld_s[n] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s[1] <= in_valid;
			for (int n = 2; n <= LAST; n++) vld_s[n] <= vld_s[n-1];
			done_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 1; n <= LAST; n++) pipe_s[n] <= nx[n];
		out_q.vel <= pipe_s[LAST].ov;
		out_q.px <= pipe_s[LAST].opx;
		out_q.py <= pipe_s[LAST].opy;
		out_q.col <= cox;
		out_q.row <= coy;
		out_q.st <= pipe_s[LAST].st;
		out_q.warn <= pipe_s[LAST].warn;
	end

	assign out_valid = done_q;
	assign out_item = out_q;

endmodule

FILE: rtl/boris_particle_push_core.sv
// top level of the boris particle push core: configuration registers and wiring
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  particle  | start / busy       | vel_*, e_*, b_*, pos_x, pos_y
//  result    | done (one cycle)   | new_vel_*, new_pos_*, cell_*, status, cfl_warning
//  config    | cfg_write          | cfg_index, cfg_data
//
// one particle per cycle is taken; the back end pipeline never stalls, so busy
// only rises if the two-entry queue fills.
// each result shows up in order; the pipeline length is set by the 17-stage
// divider for s and the two 11-stage cell dividers for the new position in
// the back end.
// reset clears all valid bits and loads the register defaults.
module boris_particle_push_core
	import bpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] e_x,
	input  logic signed [31:0] e_y,
	input  logic signed [31:0] e_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [30:0] pos_x,
	input  logic [30:0] pos_y,
	output logic done,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic [30:0] new_pos_x,
	output logic [30:0] new_pos_y,
	output logic [9:0] cell_col,
	output logic [9:0] cell_row,
	output logic [2:0] status,
	output logic cfl_warning,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	in_t item;
	logic q_full;
	logic push;
	fq_t push_item;
	logic pop;
	fq_t pop_item;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k <= 32'sd0;
			cfg_q.dt <= 31'd65536;
			cfg_q.h <= 31'd65536;
			cfg_q.xmax <= 31'd67108864;
			cfg_q.ymax <= 31'd67108864;
			cfg_q.modes <= 8'd0;
			cfg_q.half <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_K: cfg_q.k <= cfg_data;
				CFG_DT: cfg_q.dt <= cfg_data[30:0];
				CFG_H: cfg_q.h <= cfg_data[30:0];
				CFG_XMAX: cfg_q.xmax <= cfg_data[30:0];
				CFG_YMAX: cfg_q.ymax <= cfg_data[30:0];
				CFG_MODES: cfg_q.modes <= cfg_data[7:0];
				CFG_HALF: cfg_q.half <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign item.v = {vel_z, vel_y, vel_x};
	assign item.e = {e_z, e_y, e_x};
	assign item.b = {b_z, b_y, b_x};
	assign item.px = pos_x;
	assign item.py = pos_y;

	bpp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.k(cfg_q.k),
		.q_full(q_full),
		.busy(busy),
		.push(push),
		.push_item(push_item)
	);

	bpp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.pop_item(pop_item)
	);

	bpp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(pop),
		.in_item(pop_item),
		.out_valid(done),
		.out_item(res)
	);

	assign new_vel_x = res.vel[0];
	assign new_vel_y = res.vel[1];
	assign new_vel_z = res.vel[2];
	assign new_pos_x = res.px;
	assign new_pos_y = res.py;
	assign cell_col = res.col;
	assign cell_row = res.row;
	assign status = res.st;
	assign cfl_warning = res.warn;

`ifndef NO_ASSERTIONS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_GONE || status == ST_ROT ||
		status == ST_CFL || status == ST_MOVE)) else $error("bad status code");
	a_rot_no_warn: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ROT) |-> !cfl_warning) else $error("warning on rotation error");
	a_cfl_warn: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_CFL) |-> cfl_warning) else $error("courant stop without warning");
	a_gone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_GONE) |-> (new_pos_x == '0 && new_pos_y == '0 &&
		cell_col == '0 && cell_row == '0)) else $error("removed particle not cleared");
`endif

endmodule

FILE: sim/boris_particle_push_core_checker.sv
// scoreboard for the boris particle push core: tracks config, predicts each particle, compares
module boris_particle_push_core_checker
	import bpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] e_x,
	input  logic signed [31:0] e_y,
	input  logic signed [31:0] e_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [30:0] pos_x,
	input  logic [30:0] pos_y,
	input  logic done,
	input  logic signed [31:0] new_vel_x,
	input  logic signed [31:0] new_vel_y,
	input  logic signed [31:0] new_vel_z,
	input  logic [30:0] new_pos_x,
	input  logic [30:0] new_pos_y,
	input  logic [9:0] cell_col,
	input  logic [9:0] cell_row,
	input  logic [2:0] status,
	input  logic cfl_warning,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int errors,
	output int pending,
	output int checked
);

	typedef struct {
		logic signed [31:0] vx, vy, vz;
		logic [30:0] px, py;
		logic [9:0] col, row;
		logic [2:0] st;
		logic warn;
	} push_out_t;

	push_out_t push_q[$];

	logic signed [31:0] qm_k;
	logic [30:0] dt_r, h_r, xm_r, ym_r;
	logic [7:0] edge_modes;
	logic half_back;

	localparam longint TAN_BOUND = ((64'd1779033704 >> 15) + 1) >> 1;

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mul_round(input longint a, input longint b);
		longint p;
		p = a * b + 32768;
		return p >>> 16;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip32(mul_round(a, b));
	endfunction

	function automatic longint qadd(input longint a, input longint b);
		return clip32(a + b);
	endfunction

	function automatic longint qsub(input longint a, input longint b);
		return clip32(a - b);
	endfunction

	function automatic longint mag(input longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint rot_s(input longint t);
		longint den, num, q;
		den = 65536 + qmul(t, t);
		num = mag(t) << 17;
		q = (num + den / 2) / den;
		return clip32(t < 0 ? -q : q);
	endfunction

	function automatic longint cell_idx(input longint x, input longint h, input longint lim);
		longint c;
		if (x > lim - 1) x = lim - 1;
		if (x < 0) x = 0;
		c = x / h;
		return c > 1023 ? 1023 : c;
	endfunction

	// 0 stays, 1 leaves through an open edge, 4 jumps more than a cell
	function automatic int step_axis(input longint p, inout longint v, input longint dt,
		input longint h, input longint lim, input logic [1:0] ml, input logic [1:0] mr,
		output longint np);
		longint lo, x;
		lo = cell_idx(p, h, lim) * h;
		x = p + mul_round(dt, v);
		np = p;
		if (x <= lo - h || x >= lo + 2 * h) return 4;
		if (x < 0) begin
			if (ml == 0) x += lim;
			else if (ml == 1) return 1;
			else begin
				x = -x;
				v = clip32(-v);
			end
		end else if (x > lim) begin
			if (mr == 0) x -= lim;
			else if (mr == 1) return 1;
			else begin
				x = 2 * lim - x;
				v = clip32(-v);
			end
		end
		if (x < 0) x = 0;
		if (x > lim) x = lim;
		np = x;
		return 0;
	endfunction

	function automatic push_out_t predict_push(input longint v[3], input longint e[3],
		input longint b[3], input longint px, input longint py);
		push_out_t o;
		longint k, dt, h, xm, ym, nx, ny;
		longint t[3], s[3], kick[3], w[3], vm[3], vd[3], rs[3], vn[3];
		longint unsigned sum, prod, hf;
		logic [2:0] st;
		logic warn, keep, gone;
		int r;
		k = qm_k;
		dt = dt_r;
		h = h_r ? h_r : 1;
		xm = xm_r ? xm_r : 1;
		ym = ym_r ? ym_r : 1;
		st = ST_OK;
		warn = 0;
		keep = 0;
		gone = 0;
		nx = px;
		ny = py;
		vn = v;
		for (int i = 0; i < 3; i++) begin
			t[i] = qmul(k, b[i]);
			if (mag(t[i]) > TAN_BOUND) st = ST_ROT;
		end
		if (st == ST_ROT) begin
			keep = 1;
		end else begin
			if (half_back) begin
				w[0] = qsub(v[0], qmul(k, qadd(e[0], qsub(qmul(b[2], v[1]), qmul(b[1], v[2])))));
				w[1] = qsub(v[1], qmul(k, qadd(e[1], qsub(qmul(b[0], v[2]), qmul(b[2], v[0])))));
				w[2] = qsub(v[2], qmul(k, qadd(e[2], qsub(qmul(b[1], v[0]), qmul(b[0], v[1])))));
			end else begin
				w = v;
			end
			for (int i = 0; i < 3; i++) begin
				kick[i] = qmul(k, e[i]);
				vm[i] = qadd(w[i], kick[i]);
				s[i] = rot_s(t[i]);
			end
			vd[0] = qadd(vm[0], qsub(qmul(vm[1], t[2]), qmul(vm[2], t[1])));
			vd[1] = qadd(vm[1], qsub(qmul(vm[2], t[0]), qmul(vm[0], t[2])));
			vd[2] = qadd(vm[2], qsub(qmul(vm[0], t[1]), qmul(vm[1], t[0])));
			rs[0] = qadd(vm[0], qsub(qmul(vd[1], s[2]), qmul(vd[2], s[1])));
			rs[1] = qadd(vm[1], qsub(qmul(vd[2], s[0]), qmul(vd[0], s[2])));
			rs[2] = qadd(vm[2], qsub(qmul(vd[0], s[1]), qmul(vd[1], s[0])));
			for (int i = 0; i < 3; i++) vn[i] = qadd(rs[i], kick[i]);
			sum = mag(vn[0]) + mag(vn[1]) + mag(vn[2]);
			prod = sum * longint'(dt);
			hf = longint'(h) << 16;
			warn = prod > hf;
			if (prod > hf + hf / 2) begin
				st = ST_CFL;
				keep = 1;
			end else begin
				r = step_axis(px, vn[0], dt, h, xm, edge_modes[1:0], edge_modes[3:2], nx);
				if (r == 0)
					r = step_axis(py, vn[1], dt, h, ym, edge_modes[5:4], edge_modes[7:6], ny);
				if (r == 4) begin
					st = ST_MOVE;
					keep = 1;
				end else if (r == 1) begin
					st = ST_GONE;
					gone = 1;
				end
			end
		end
		if (keep) begin
			vn = v;
			nx = px;
			ny = py;
		end
		if (gone) begin
			o = '{default: '0};
		end else begin
			o.vx = vn[0];
			o.vy = vn[1];
			o.vz = vn[2];
			o.px = nx;
			o.py = ny;
			o.col = cell_idx(nx, h, xm);
			o.row = cell_idx(ny, h, ym);
		end
		o.st = st;
		o.warn = warn;
		return o;
	endfunction

	assign pending = push_q.size();

	always @(posedge clk or negedge arst_n) begin
		longint v[3], e[3], b[3];
		push_out_t exp_o;
		if (!arst_n) begin
			qm_k <= 0;
			dt_r <= 31'd65536;
			h_r <= 31'd65536;
			xm_r <= 31'd67108864;
			ym_r <= 31'd67108864;
			edge_modes <= 0;
			half_back <= 0;
			errors <= 0;
			checked <= 0;
			push_q.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_K: qm_k <= cfg_data;
					CFG_DT: dt_r <= cfg_data[30:0];
					CFG_H: h_r <= cfg_data[30:0];
					CFG_XMAX: xm_r <= cfg_data[30:0];
					CFG_YMAX: ym_r <= cfg_data[30:0];
					CFG_MODES: edge_modes <= cfg_data[7:0];
					CFG_HALF: half_back <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				v = '{vel_x, vel_y, vel_z};
				e = '{e_x, e_y, e_z};
				b = '{b_x, b_y, b_z};
				push_q.push_back(predict_push(v, e, b, pos_x, pos_y));
			end
			if (done) begin
				if (push_q.size() == 0) begin
					if (errors < 10) $display("result with no transaction pending");
					errors <= errors + 1;
				end else begin
					exp_o = push_q.pop_front();
					checked <= checked + 1;
					if (exp_o.vx !== new_vel_x || exp_o.vy !== new_vel_y ||
						exp_o.vz !== new_vel_z || exp_o.px !== new_pos_x ||
						exp_o.py !== new_pos_y || exp_o.col !== cell_col ||
						exp_o.row !== cell_row || exp_o.st !== status ||
						exp_o.warn !== cfl_warning) begin
						if (errors < 10) begin
							$display("exp v=%0d %0d %0d p=%0d %0d c=%0d %0d st=%0d w=%0d",
								exp_o.vx, exp_o.vy, exp_o.vz, exp_o.px, exp_o.py,
								exp_o.col, exp_o.row, exp_o.st, exp_o.warn);
							$display("got v=%0d %0d %0d p=%0d %0d c=%0d %0d st=%0d w=%0d",
								new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y,
								cell_col, cell_row, status, cfl_warning);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

FILE: sim/boris_particle_push_core_test.sv
// testbench top of the boris particle push core: stimulus, config phases and verdict
module boris_particle_push_core_test;
	import bpp_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES = 9;
	localparam int PER_PHASE = 150;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
	logic signed [31:0] e_x = 0, e_y = 0, e_z = 0;
	logic signed [31:0] b_x = 0, b_y = 0, b_z = 0;
	logic [30:0] pos_x = 0, pos_y = 0;
	logic done;
	logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
	logic [30:0] new_pos_x, new_pos_y;
	logic [9:0] cell_col, cell_row;
	logic [2:0] status;
	logic cfl_warning;
	logic cfg_write = 0;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int errors, pending, checked;
	int quiet = 0;
	int sent = 0;
	int idle_pct = 0;

	longint cur_k, cur_dt, cur_h, cur_xm, cur_ym;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	boris_particle_push_core uut (.*);
	boris_particle_push_core_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > QUIET_LIMIT) begin
			$display("boris_particle_push_core: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val[31:0];
		@(posedge clk);
	endtask

	task automatic set_config(input longint k, input longint dt, input longint h,
		input longint xm, input longint ym, input logic [7:0] modes, input logic half);
		write_reg(CFG_K, k);
		write_reg(CFG_DT, dt);
		write_reg(CFG_H, h);
		write_reg(CFG_XMAX, xm);
		write_reg(CFG_YMAX, ym);
		write_reg(CFG_MODES, modes);
		write_reg(CFG_HALF, half);
		cfg_write <= 0;
		cur_k = k;
		cur_dt = dt;
		cur_h = h ? h : 1;
		cur_xm = xm ? xm : 1;
		cur_ym = ym ? ym : 1;
	endtask

	// wait out everything in flight before touching the registers
	task automatic drain;
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic send(input longint vx, input longint vy, input longint vz,
		input longint ex, input longint ey, input longint ez, input longint bx,
		input longint by, input longint bz, input longint px, input longint py);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		vel_x <= vx[31:0];
		vel_y <= vy[31:0];
		vel_z <= vz[31:0];
		e_x <= ex[31:0];
		e_y <= ey[31:0];
		e_z <= ez[31:0];
		b_x <= bx[31:0];
		b_y <= by[31:0];
		b_z <= bz[31:0];
		pos_x <= px[30:0];
		pos_y <= py[30:0];
		start <= 1;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	function automatic longint srand(input longint m);
		return longint'($urandom_range(0, 32'(2 * m))) - m;
	endfunction

	function automatic longint place(input longint lim);
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return longint'($urandom_range(0, 32'(cur_h < lim ? cur_h : lim)));
		if (sel == 1) return lim - longint'($urandom_range(0, 32'(cur_h < lim ? cur_h : lim)));
		return longint'($urandom_range(0, 32'(lim)));
	endfunction

	task automatic send_random;
		longint vmax, bmax, emax;
		if ($urandom_range(99) < 25) begin
			send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			vmax = (cur_h * 65536) / (4 * (cur_dt + 1));
			if ($urandom_range(9) == 0) vmax = vmax * 6;
			if (vmax > (64'd1 << 30)) vmax = 64'd1 << 30;
			if (vmax < 1) vmax = 1;
			bmax = (64'd30000 * 65536) / ((cur_k < 0 ? -cur_k : cur_k) + 1);
			if (bmax > (64'd1 << 30)) bmax = 64'd1 << 30;
			emax = vmax;
			send(srand(vmax), srand(vmax), srand(vmax), srand(emax), srand(emax),
				srand(emax), srand(bmax), srand(bmax), srand(bmax),
				place(cur_xm), place(cur_ym));
		end
	endtask

	initial begin
		logic [7:0] mode_set[4];
		mode_set = '{8'h00, 8'h55, 8'hAA, 8'hFF};
		cur_k = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part: edges, boundary codes and the special cases
		for (int m = 0; m < 4; m++) begin
			drain();
			set_config(4096, 16384, 65536, 8 << 16, 8 << 16, mode_set[m], m == 3);
			send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
			send(-262144, -131072, 0, 0, 0, 0, 0, 0, 65536, 1000, 2000);
			send(262144, 131072, 5, 100, -100, 7, 0, 0, 0, 8 << 16, 8 << 16);
			send(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
				32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF);
			send(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 65535, 65536);
			send(340000, 0, 0, 0, 0, 0, 0, 0, 0, 131000, 3 << 16);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			idle_pct = p < 3 ? 37 : (p < 6 ? 83 : 0);
			case (p)
				0: set_config(32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
					31'h7FFFFFFF, 8'hFF, 1);
				1: set_config(-2147483648, 0, 0, 0, 0, 8'h00, 0);
				2: set_config(-4096, 1 << 16, 1 << 16, 1, 31'h7FFFFFFF, 8'h1B, 1);
				default: set_config(srand(1 << 13), $urandom_range(0, 1 << 17),
					$urandom_range(1 << 12, 1 << 18), $urandom_range(1 << 16, 1 << 22),
					$urandom_range(1 << 16, 1 << 22), $urandom_range(0, 255),
					$urandom_range(0, 1));
			endcase
			for (int i = 0; i < PER_PHASE; i++) send_random();
			drain();
		end

		$display("%0d particles over %0d register settings, %0d results compared",
			sent, PHASES + 4, checked);
		if (errors == 0 && pending == 0)
			$display("boris_particle_push_core: match");
		else
			$display("boris_particle_push_core: mismatch");
		$finish;
	end

endmodule
